// ===== src/cpsic_pkg.sv =====
package cpsic_pkg;

	localparam int DATA_W  = 32;
	localparam int INTEG_W = 48;

	localparam int CFG_AW = 6;
	localparam int CFG_DW = 64;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		data_t position_measured;
		data_t speed_measured;
		data_t position_target;
		data_t speed_target;
		data_t accel_target;
	} in_word_t;

	typedef struct packed {
		data_t current_command;
		data_t speed_from_position;
	} out_word_t;

	typedef enum logic [2:0] {
		REG_CONTROL_MODE  = 3'd0,
		REG_POS_GAINS     = 3'd1,
		REG_SPEED_LIMIT   = 3'd2,
		REG_SPEED_PI      = 3'd3,
		REG_PATH_GAIN     = 3'd4,
		REG_CURRENT_LIMIT = 3'd5,
		REG_FF_INERTIA    = 3'd6,
		REG_FF_TORQUE     = 3'd7
	} reg_idx_t;

	localparam logic [1:0] MODE_SPEED = 2'd0;
	localparam logic [1:0] MODE_POS   = 2'd1;
	localparam logic [1:0] MODE_TRAJ  = 2'd2;

	localparam logic [30:0]        SPEED_LIMIT_RST = 31'h7fff_ffff;
	localparam logic signed [31:0] PATH_GAIN_RST   = 32'sd65536;

	localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic signed [79:0] PROD_LIM   = 80'sh2000_0000_0000_0000;
	localparam logic signed [63:0] PROD_LIM64 = 64'sh2000_0000_0000_0000;

	typedef struct packed {
		logic en;
		logic hi;
	} mul_ctl_t;

endpackage

// ===== src/cpsic_mul.sv =====
module cpsic_mul (
	input  logic                clk,
	input  cpsic_pkg::mul_ctl_t ctl,
	input  logic signed [63:0]  op_a,
	input  logic signed [31:0]  op_b,
	output logic signed [63:0]  res
);

	logic signed [32:0] part_a;
	logic signed [64:0] prod;
	logic signed [95:0] prod_w;
	logic signed [95:0] acc_q;
	logic signed [79:0] shr;

	// The low half of the wide operand is unsigned, the high half carries the sign.
	assign part_a = ctl.hi ? $signed({op_a[63], op_a[63:32]}) : $signed({1'b0, op_a[31:0]});
	assign prod   = part_a * op_b;
	assign prod_w = 96'(prod);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.hi) begin
				acc_q <= acc_q + (prod_w <<< 32);
			end else begin
				acc_q <= prod_w;
			end
		end
	end

	assign shr = acc_q[95:16];

	always_comb begin
		if (shr > cpsic_pkg::PROD_LIM) begin
			res = cpsic_pkg::PROD_LIM64;
		end else if (shr < -cpsic_pkg::PROD_LIM) begin
			res = -cpsic_pkg::PROD_LIM64;
		end else begin
			res = shr[63:0];
		end
	end

endmodule

// ===== src/cascaded_position_speed_iq_controller.sv =====
// Cascaded position and speed controller that turns one sample word (measured position and
// speed, position, speed and acceleration targets) into one result word holding the q-axis
// current command and the clamped position loop output. All values are signed Q16.16. Every
// product goes through a single 33 by 32 bit multiplier, two passes per product. A sample
// is finished only once its result word can be passed on, which result_stall can hold back.
// The sample side stalls while a sample is being worked on. Registers are written and read
// through the APB port at byte address 8 times the register index.
module cascaded_position_speed_iq_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cpsic_pkg::CFG_AW-1:0]    paddr,
	input  logic [cpsic_pkg::CFG_DW-1:0]    pwdata,
	output logic [cpsic_pkg::CFG_DW-1:0]    prdata,
	output logic                            pready,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  cpsic_pkg::in_word_t             sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output cpsic_pkg::out_word_t            result
);

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00_0000_0000_0001,
		ST_POS  = 14'b00_0000_0000_0010,
		ST_SFP  = 14'b00_0000_0000_0100,
		ST_TRAJ = 14'b00_0000_0000_1000,
		ST_TSUM = 14'b00_0000_0001_0000,
		ST_ERR  = 14'b00_0000_0010_0000,
		ST_KP   = 14'b00_0000_0100_0000,
		ST_KI   = 14'b00_0000_1000_0000,
		ST_PI   = 14'b00_0001_0000_0000,
		ST_FFJ  = 14'b00_0010_0000_0000,
		ST_FFB  = 14'b00_0100_0000_0000,
		ST_PATH = 14'b00_1000_0000_0000,
		ST_SUM  = 14'b01_0000_0000_0000,
		ST_OUT  = 14'b10_0000_0000_0000
	} state_t;

	localparam int DW = cpsic_pkg::DATA_W;
	localparam int IW = cpsic_pkg::INTEG_W;

	logic [1:0]         mode_q;
	logic [63:0]        pos_gains_q;
	logic [30:0]        speed_limit_q;
	logic [63:0]        pi_gains_q;
	logic signed [31:0] path_gain_q;
	logic [63:0]        cur_lim_q;
	logic [63:0]        ff_coef_q;
	logic signed [31:0] torque_q;

	state_t state_q;
	state_t mul_next;
	logic   phase_q;
	logic   is_mul;
	logic   result_valid_q;
	logic   out_free;
	logic   wr_en;

	logic signed [IW-1:0] integ_q;
	logic signed [IW-1:0] integ_sat;
	logic signed [IW:0]   isum_q;
	logic signed [DW:0]   pos_err_q;
	logic signed [DW:0]   err_q;
	cpsic_pkg::data_t     spd_m_q;
	cpsic_pkg::data_t     spd_t_q;
	cpsic_pkg::data_t     acc_t_q;
	cpsic_pkg::data_t     spd_cmd_q;
	cpsic_pkg::data_t     sfp_q;
	logic signed [63:0]   pkp_q;
	logic signed [63:0]   pi_q;
	logic signed [63:0]   ff_q;
	cpsic_pkg::out_word_t result_q;

	cpsic_pkg::mul_ctl_t mul_ctl;
	logic signed [63:0]  mul_a;
	logic signed [31:0]  mul_b;
	logic signed [63:0]  mul_res;

	logic signed [31:0] cur_max;
	logic signed [31:0] cur_min;
	logic signed [63:0] lim64;
	logic signed [63:0] sfp_full;
	cpsic_pkg::data_t   sfp_n;
	logic signed [64:0] traj_sum;
	cpsic_pkg::data_t   traj_sat;
	logic               hold;
	cpsic_pkg::data_t   cmd_n;
	logic               pos_mode;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= cpsic_pkg::MODE_SPEED;
			pos_gains_q   <= '0;
			speed_limit_q <= cpsic_pkg::SPEED_LIMIT_RST;
			pi_gains_q    <= '0;
			path_gain_q   <= cpsic_pkg::PATH_GAIN_RST;
			cur_lim_q     <= '0;
			ff_coef_q     <= '0;
			torque_q      <= '0;
		end else if (wr_en) begin
			unique case (cpsic_pkg::reg_idx_t'(paddr[5:3]))
				cpsic_pkg::REG_CONTROL_MODE:  mode_q        <= pwdata[1:0];
				cpsic_pkg::REG_POS_GAINS:     pos_gains_q   <= pwdata;
				cpsic_pkg::REG_SPEED_LIMIT:   speed_limit_q <= pwdata[30:0];
				cpsic_pkg::REG_SPEED_PI:      pi_gains_q    <= pwdata;
				cpsic_pkg::REG_PATH_GAIN:     path_gain_q   <= pwdata[31:0];
				cpsic_pkg::REG_CURRENT_LIMIT: cur_lim_q     <= pwdata;
				cpsic_pkg::REG_FF_INERTIA:    ff_coef_q     <= pwdata;
				cpsic_pkg::REG_FF_TORQUE:     torque_q      <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cpsic_pkg::reg_idx_t'(paddr[5:3]))
			cpsic_pkg::REG_CONTROL_MODE:  prdata = 64'(mode_q);
			cpsic_pkg::REG_POS_GAINS:     prdata = pos_gains_q;
			cpsic_pkg::REG_SPEED_LIMIT:   prdata = 64'(speed_limit_q);
			cpsic_pkg::REG_SPEED_PI:      prdata = pi_gains_q;
			cpsic_pkg::REG_PATH_GAIN:     prdata = {32'd0, path_gain_q};
			cpsic_pkg::REG_CURRENT_LIMIT: prdata = cur_lim_q;
			cpsic_pkg::REG_FF_INERTIA:    prdata = ff_coef_q;
			cpsic_pkg::REG_FF_TORQUE:     prdata = {32'd0, torque_q};
			default:                      prdata = '0;
		endcase
	end

	assign cur_max  = cur_lim_q[63:32];
	assign cur_min  = cur_lim_q[31:0];
	assign pos_mode = (mode_q == cpsic_pkg::MODE_POS) || (mode_q == cpsic_pkg::MODE_TRAJ);

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || !result_stall;

	always_comb begin
		is_mul   = 1'b1;
		mul_next = ST_IDLE;
		mul_a    = pi_q;
		mul_b    = path_gain_q;
		unique case (state_q)
			ST_POS: begin
				mul_a    = 64'(pos_err_q);
				mul_b    = pos_gains_q[31:0];
				mul_next = ST_SFP;
			end
			ST_TRAJ: begin
				mul_a    = 64'(sfp_q);
				mul_b    = pos_gains_q[63:32];
				mul_next = ST_TSUM;
			end
			ST_KP: begin
				mul_a    = 64'(err_q);
				mul_b    = pi_gains_q[31:0];
				mul_next = ST_KI;
			end
			ST_KI: begin
				mul_a    = 64'(isum_q);
				mul_b    = pi_gains_q[63:32];
				mul_next = ST_PI;
			end
			ST_FFJ: begin
				mul_a    = 64'(acc_t_q);
				mul_b    = ff_coef_q[31:0];
				mul_next = ST_FFB;
			end
			ST_FFB: begin
				mul_a    = 64'(spd_m_q);
				mul_b    = ff_coef_q[63:32];
				mul_next = ST_PATH;
			end
			ST_PATH: begin
				mul_next = ST_SUM;
			end
			default: begin
				is_mul = 1'b0;
			end
		endcase
	end

	assign mul_ctl.en = is_mul;
	assign mul_ctl.hi = phase_q;

	cpsic_mul u_mul (
		.clk  (clk),
		.ctl  (mul_ctl),
		.op_a (mul_a),
		.op_b (mul_b),
		.res  (mul_res)
	);

	assign lim64 = $signed({33'd0, speed_limit_q});

	always_comb begin
		if (mul_res >= lim64) begin
			sfp_full = lim64;
		end else if (mul_res <= -lim64) begin
			sfp_full = -lim64;
		end else begin
			sfp_full = mul_res;
		end
	end

	assign sfp_n    = sfp_full[DW-1:0];
	assign traj_sum = 65'(spd_t_q) + 65'(mul_res);

	always_comb begin
		if (traj_sum > 65'(cpsic_pkg::DATA_MAX)) begin
			traj_sat = cpsic_pkg::DATA_MAX;
		end else if (traj_sum < 65'(cpsic_pkg::DATA_MIN)) begin
			traj_sat = cpsic_pkg::DATA_MIN;
		end else begin
			traj_sat = traj_sum[DW-1:0];
		end
	end

	always_comb begin
		if (isum_q[IW] != isum_q[IW-1]) begin
			integ_sat = {isum_q[IW], {(IW-1){~isum_q[IW]}}};
		end else begin
			integ_sat = isum_q[IW-1:0];
		end
	end

	always_comb begin
		hold = 1'b0;
		if (pi_q >= 64'(cur_max)) begin
			hold = (err_q > 0);
		end else if (pi_q <= 64'(cur_min)) begin
			hold = (err_q < 0);
		end
	end

	always_comb begin
		if (ff_q >= 64'(cur_max)) begin
			cmd_n = DW'(cur_max);
		end else if (ff_q <= 64'(cur_min)) begin
			cmd_n = DW'(cur_min);
		end else begin
			cmd_n = ff_q[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			phase_q        <= 1'b0;
			result_valid_q <= 1'b0;
			integ_q        <= '0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (state_q == ST_FFJ && !phase_q && !hold) begin
				integ_q <= integ_sat;
			end
			if (is_mul) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					state_q <= mul_next;
				end
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (sample_valid) begin
							state_q <= pos_mode ? ST_POS : ST_ERR;
						end
					end
					ST_SFP: begin
						state_q <= (mode_q == cpsic_pkg::MODE_POS) ? ST_ERR : ST_TRAJ;
					end
					ST_TSUM: state_q <= ST_ERR;
					ST_ERR:  state_q <= ST_KP;
					ST_PI:   state_q <= ST_FFJ;
					ST_SUM:  state_q <= ST_OUT;
					ST_OUT: begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					pos_err_q <= (DW+1)'(sample.position_target)
						- (DW+1)'(sample.position_measured);
					spd_m_q   <= sample.speed_measured;
					spd_t_q   <= sample.speed_target;
					acc_t_q   <= sample.accel_target;
					spd_cmd_q <= sample.speed_target;
					sfp_q     <= '0;
				end
			end
			ST_SFP: begin
				sfp_q     <= sfp_n;
				spd_cmd_q <= sfp_n;
			end
			ST_TSUM: spd_cmd_q <= traj_sat;
			ST_ERR:  err_q <= (DW+1)'(spd_cmd_q) - (DW+1)'(spd_m_q);
			ST_KP: begin
				if (!phase_q) begin
					isum_q <= (IW+1)'(integ_q) + (IW+1)'(err_q);
				end
			end
			ST_KI: begin
				if (!phase_q) begin
					pkp_q <= mul_res;
				end
			end
			ST_PI: pi_q <= pkp_q + mul_res;
			ST_FFB: begin
				if (!phase_q) begin
					ff_q <= mul_res + 64'(torque_q);
				end
			end
			ST_PATH: begin
				if (!phase_q) begin
					ff_q <= ff_q + mul_res;
				end
			end
			ST_SUM: ff_q <= ff_q + mul_res;
			ST_OUT: begin
				if (out_free) begin
					result_q.current_command     <= cmd_n;
					result_q.speed_from_position <= sfp_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

	typedef logic signed [63:0] wide_t;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam wide_t PRODUCT_BOUND = 64'sh2000_0000_0000_0000;
	localparam wide_t INTEG_HIGH    = 64'sh0000_7fff_ffff_ffff;
	localparam wide_t INTEG_LOW     = -INTEG_HIGH - 1;
	localparam wide_t WORD_HIGH     = 64'sd2147483647;
	localparam wide_t WORD_LOW      = -64'sd2147483648;
	localparam int    CYCLE_LIMIT   = 3000000;
	localparam cpsic_pkg::data_t SAMPLE_MAX = cpsic_pkg::DATA_MAX;
	localparam cpsic_pkg::data_t SAMPLE_MIN = cpsic_pkg::DATA_MIN;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [cpsic_pkg::CFG_AW-1:0]    paddr;
	logic [cpsic_pkg::CFG_DW-1:0]    pwdata;
	logic [cpsic_pkg::CFG_DW-1:0]    prdata;
	logic                            pready;
	logic                            sample_valid;
	logic                            sample_stall;
	cpsic_pkg::in_word_t             sample;
	logic                            result_valid;
	logic                            result_stall;
	cpsic_pkg::out_word_t            result;

	logic [1:0]           mode_shadow;
	logic [63:0]          pos_gains_shadow;
	logic [30:0]          speed_limit_shadow;
	logic [63:0]          pi_gains_shadow;
	logic signed [31:0]   path_gain_shadow;
	logic [63:0]          current_limits_shadow;
	logic [63:0]          ff_coef_shadow;
	logic signed [31:0]   ff_torque_shadow;
	wide_t                speed_integral;

	cpsic_pkg::out_word_t pending_commands[$];
	int                   mismatch_count;
	int                   cycle_count;
	bit                   tx_idling;
	bit                   rx_idling;
	int                   hold_off_cycles;
	int                   stall_left;

	cascaded_position_speed_iq_controller dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic wide_t q_product(wide_t a, wide_t b);
		logic signed [127:0] pa;
		logic signed [127:0] pb;
		logic signed [127:0] p;
		pa = a;
		pb = b;
		p = (pa * pb) >>> 16;
		if (p > PRODUCT_BOUND)
			return PRODUCT_BOUND;
		if (p < -PRODUCT_BOUND)
			return -PRODUCT_BOUND;
		return p[63:0];
	endfunction

	function automatic cpsic_pkg::out_word_t predict_current_command(cpsic_pkg::in_word_t s);
		wide_t pos_m;
		wide_t spd_m;
		wide_t pos_t;
		wide_t spd_cmd;
		wide_t acc_t;
		wide_t cur_max;
		wide_t cur_min;
		wide_t lim;
		wide_t sfp;
		wide_t err;
		wide_t pi;
		wide_t acc;
		wide_t sum;
		bit hold;
		cpsic_pkg::out_word_t o;
		pos_m = s.position_measured;
		spd_m = s.speed_measured;
		pos_t = s.position_target;
		spd_cmd = s.speed_target;
		acc_t = s.accel_target;
		cur_max = $signed(current_limits_shadow[63:32]);
		cur_min = $signed(current_limits_shadow[31:0]);
		sfp = 0;
		if (mode_shadow == cpsic_pkg::MODE_POS || mode_shadow == cpsic_pkg::MODE_TRAJ) begin
			lim = {33'b0, speed_limit_shadow};
			sfp = q_product(pos_t - pos_m, $signed(pos_gains_shadow[31:0]));
			if (sfp >= lim)
				sfp = lim;
			else if (sfp <= -lim)
				sfp = -lim;
			if (mode_shadow == cpsic_pkg::MODE_POS) begin
				spd_cmd = sfp;
			end else begin
				spd_cmd = spd_cmd + q_product($signed(pos_gains_shadow[63:32]), sfp);
				if (spd_cmd > WORD_HIGH)
					spd_cmd = WORD_HIGH;
				else if (spd_cmd < WORD_LOW)
					spd_cmd = WORD_LOW;
			end
		end
		err = spd_cmd - spd_m;
		pi = q_product(err, $signed(pi_gains_shadow[31:0])) +
			q_product(speed_integral + err, $signed(pi_gains_shadow[63:32]));
		hold = 1'b0;
		if (pi >= cur_max) begin
			if (err > 0)
				hold = 1'b1;
		end else if (pi <= cur_min) begin
			if (err < 0)
				hold = 1'b1;
		end
		if (!hold) begin
			sum = speed_integral + err;
			if (sum > INTEG_HIGH)
				sum = INTEG_HIGH;
			else if (sum < INTEG_LOW)
				sum = INTEG_LOW;
			speed_integral = sum;
		end
		acc = q_product($signed(ff_coef_shadow[31:0]), acc_t) +
			q_product($signed(ff_coef_shadow[63:32]), spd_m) + ff_torque_shadow;
		acc = acc + q_product(pi, path_gain_shadow);
		if (acc >= cur_max)
			acc = cur_max;
		else if (acc <= cur_min)
			acc = cur_min;
		o.current_command = acc[31:0];
		o.speed_from_position = sfp[31:0];
		return o;
	endfunction

	function automatic cpsic_pkg::in_word_t make_sample(cpsic_pkg::data_t pm,
		cpsic_pkg::data_t sm, cpsic_pkg::data_t pt, cpsic_pkg::data_t st,
		cpsic_pkg::data_t at);
		cpsic_pkg::in_word_t w;
		w.position_measured = pm;
		w.speed_measured = sm;
		w.position_target = pt;
		w.speed_target = st;
		w.accel_target = at;
		return w;
	endfunction

	function automatic cpsic_pkg::data_t rand_data();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return $urandom;
			default: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
		endcase
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return $urandom;
			default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
		endcase
	endfunction

	function automatic cpsic_pkg::in_word_t rand_sample();
		cpsic_pkg::in_word_t w;
		w = make_sample(rand_data(), rand_data(), rand_data(), rand_data(), rand_data());
		if ($urandom_range(0, 2) == 0)
			w.position_measured = w.position_target + (int'($urandom_range(0, 1 << 17)) - (1 << 16));
		return w;
	endfunction

	task automatic write_reg(cpsic_pkg::reg_idx_t idx, logic [63:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			cpsic_pkg::REG_CONTROL_MODE:  mode_shadow = value[1:0];
			cpsic_pkg::REG_POS_GAINS:     pos_gains_shadow = value;
			cpsic_pkg::REG_SPEED_LIMIT:   speed_limit_shadow = value[30:0];
			cpsic_pkg::REG_SPEED_PI:      pi_gains_shadow = value;
			cpsic_pkg::REG_PATH_GAIN:     path_gain_shadow = value[31:0];
			cpsic_pkg::REG_CURRENT_LIMIT: current_limits_shadow = value;
			cpsic_pkg::REG_FF_INERTIA:    ff_coef_shadow = value;
			cpsic_pkg::REG_FF_TORQUE:     ff_torque_shadow = value[31:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_sample(cpsic_pkg::in_word_t w);
		if (tx_idling && $urandom_range(0, 5) == 0) begin
			sample_valid = 1'b0;
			repeat ($urandom_range(1, 16))
				@(negedge clk);
		end
		sample_valid = 1'b1;
		sample = w;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		pending_commands.push_back(predict_current_command(w));
		@(negedge clk);
	endtask

	task automatic drain();
		sample_valid = 1'b0;
		while (pending_commands.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_reset_defaults();
		send_sample(make_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
		send_sample(make_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN));
		drain();
	endtask

	task automatic test_speed_mode();
		write_reg(cpsic_pkg::REG_CONTROL_MODE, {62'b0, cpsic_pkg::MODE_SPEED});
		write_reg(cpsic_pkg::REG_SPEED_PI, {32'h0000_028f, 32'h0001_8000});
		write_reg(cpsic_pkg::REG_PATH_GAIN, 64'h0001_0000);
		write_reg(cpsic_pkg::REG_CURRENT_LIMIT, {32'h0032_0000, 32'hffce_0000});
		write_reg(cpsic_pkg::REG_FF_INERTIA, {32'h0000_0ccd, 32'h0000_3333});
		write_reg(cpsic_pkg::REG_FF_TORQUE, 64'h0000_4ccd);
		send_sample(make_sample(0, 32'h0002_0000, 0, 32'h0003_0000, 32'h0001_0000));
		send_sample(make_sample(0, SAMPLE_MIN, 0, SAMPLE_MAX, SAMPLE_MAX));
		send_sample(make_sample(0, SAMPLE_MAX, 0, SAMPLE_MIN, SAMPLE_MIN));
		drain();
	endtask

	task automatic test_position_mode();
		write_reg(cpsic_pkg::REG_CONTROL_MODE, {62'b0, cpsic_pkg::MODE_POS});
		write_reg(cpsic_pkg::REG_POS_GAINS, {32'h0000_8000, 32'h0002_0000});
		write_reg(cpsic_pkg::REG_SPEED_LIMIT, 64'h000a_0000);
		send_sample(make_sample(32'h0001_0000, 0, 32'h0003_0000, 0, 0));
		send_sample(make_sample(SAMPLE_MIN, 0, SAMPLE_MAX, 0, 0));
		send_sample(make_sample(SAMPLE_MAX, 0, SAMPLE_MIN, 0, 0));
		drain();
		write_reg(cpsic_pkg::REG_SPEED_LIMIT, 64'h0);
		send_sample(make_sample(0, 0, 32'h0005_0000, 0, 0));
		send_sample(make_sample(32'h0005_0000, 0, 0, 0, 0));
		drain();
	endtask

	task automatic test_trajectory_mode();
		write_reg(cpsic_pkg::REG_CONTROL_MODE, {62'b0, cpsic_pkg::MODE_TRAJ});
		write_reg(cpsic_pkg::REG_SPEED_LIMIT, {33'b0, cpsic_pkg::SPEED_LIMIT_RST});
		write_reg(cpsic_pkg::REG_POS_GAINS, {32'h7fff_ffff, 32'h0001_0000});
		send_sample(make_sample(0, 0, 32'h1000_0000, SAMPLE_MAX, 0));
		send_sample(make_sample(32'h1000_0000, 0, 0, SAMPLE_MIN, 0));
		send_sample(make_sample(0, 32'h0001_0000, 32'h0000_0100, 32'h0002_0000, 0));
		drain();
		write_reg(cpsic_pkg::REG_CONTROL_MODE, {62'b0, MODE_UNUSED});
		send_sample(make_sample(0, 0, 32'h1000_0000, 32'h0001_0000, 0));
		send_sample(make_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN));
		drain();
	endtask

	task automatic test_crossed_limits();
		write_reg(cpsic_pkg::REG_CONTROL_MODE, {62'b0, cpsic_pkg::MODE_SPEED});
		write_reg(cpsic_pkg::REG_CURRENT_LIMIT, {32'hffff_0000, 32'h0001_0000});
		send_sample(make_sample(0, 0, 0, 0, 0));
		send_sample(make_sample(0, 0, 0, SAMPLE_MAX, SAMPLE_MAX));
		send_sample(make_sample(0, 0, 0, SAMPLE_MIN, SAMPLE_MIN));
		drain();
	endtask

	task automatic test_gain_extremes();
		write_reg(cpsic_pkg::REG_CONTROL_MODE, {62'b0, cpsic_pkg::MODE_TRAJ});
		write_reg(cpsic_pkg::REG_POS_GAINS, {32'h8000_0000, 32'h8000_0000});
		write_reg(cpsic_pkg::REG_SPEED_PI, {32'h8000_0000, 32'h7fff_ffff});
		write_reg(cpsic_pkg::REG_PATH_GAIN, 64'h0000_0000_8000_0000);
		write_reg(cpsic_pkg::REG_CURRENT_LIMIT, {32'h7fff_ffff, 32'h8000_0000});
		write_reg(cpsic_pkg::REG_FF_INERTIA, {32'h7fff_ffff, 32'h8000_0000});
		write_reg(cpsic_pkg::REG_FF_TORQUE, 64'h0000_0000_8000_0000);
		send_sample(make_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX));
		send_sample(make_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN));
		send_sample(make_sample(0, 32'hffff_ffff, 32'h0000_0001, 0, 32'hffff_ffff));
		drain();
	endtask

	task automatic test_integral_saturation();
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		write_reg(cpsic_pkg::REG_CONTROL_MODE, {62'b0, cpsic_pkg::MODE_SPEED});
		write_reg(cpsic_pkg::REG_SPEED_PI, 64'h0);
		write_reg(cpsic_pkg::REG_PATH_GAIN, 64'h0000_0001);
		write_reg(cpsic_pkg::REG_CURRENT_LIMIT, {32'h7fff_ffff, 32'h8000_0000});
		write_reg(cpsic_pkg::REG_FF_INERTIA, 64'h0);
		write_reg(cpsic_pkg::REG_FF_TORQUE, 64'h0);
		for (int i = 0; i < 40; i++)
			send_sample(make_sample(rand_data(), SAMPLE_MIN, rand_data(), SAMPLE_MAX,
				rand_data()));
		drain();
		write_reg(cpsic_pkg::REG_SPEED_PI, {32'h0000_0001, 32'h0});
		send_sample(make_sample(0, 0, 0, 0, 0));
		send_sample(make_sample(0, SAMPLE_MIN, 0, SAMPLE_MAX, 0));
		send_sample(make_sample(0, SAMPLE_MAX, 0, SAMPLE_MIN, 0));
		drain();
	endtask

	task automatic test_backpressure();
		tx_idling = 1'b0;
		hold_off_cycles = 300;
		for (int i = 0; i < 8; i++)
			send_sample(rand_sample());
		drain();
	endtask

	task automatic randomize_settings();
		logic [31:0] cmax;
		logic [31:0] cmin;
		write_reg(cpsic_pkg::REG_CONTROL_MODE, {62'b0, 2'($urandom_range(0, 3))});
		write_reg(cpsic_pkg::REG_POS_GAINS, {rand_gain(), rand_gain()});
		case ($urandom_range(0, 4))
			0: write_reg(cpsic_pkg::REG_SPEED_LIMIT, 64'h0);
			1: write_reg(cpsic_pkg::REG_SPEED_LIMIT, {33'b0, cpsic_pkg::SPEED_LIMIT_RST});
			default: write_reg(cpsic_pkg::REG_SPEED_LIMIT, 64'($urandom_range(0, 1 << 22)));
		endcase
		write_reg(cpsic_pkg::REG_SPEED_PI, {rand_gain(), rand_gain()});
		write_reg(cpsic_pkg::REG_PATH_GAIN, {32'b0, rand_gain()});
		case ($urandom_range(0, 5))
			0: begin
				cmax = $urandom;
				cmin = $urandom;
			end
			1: begin
				cmax = 32'h7fff_ffff;
				cmin = 32'h8000_0000;
			end
			2: begin
				cmax = -int'($urandom_range(0, 1 << 20));
				cmin = $urandom_range(0, 1 << 20);
			end
			default: begin
				cmax = $urandom_range(0, 1 << 23);
				cmin = -int'($urandom_range(0, 1 << 23));
			end
		endcase
		write_reg(cpsic_pkg::REG_CURRENT_LIMIT, {cmax, cmin});
		write_reg(cpsic_pkg::REG_FF_INERTIA, {rand_gain(), rand_gain()});
		write_reg(cpsic_pkg::REG_FF_TORQUE, {32'b0, rand_gain()});
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 9; phase++) begin
			drain();
			randomize_settings();
			tx_idling = (phase < 8) && ($urandom_range(0, 3) != 0);
			rx_idling = (phase < 8) && ($urandom_range(0, 3) != 0);
			for (int i = 0; i < 100; i++)
				send_sample(rand_sample());
		end
		drain();
	endtask

	// The receiver holds off either for a requested stretch or in random bursts.
	initial begin
		result_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				result_stall = 1'b1;
				hold_off_cycles--;
			end else if (stall_left > 0) begin
				result_stall = 1'b1;
				stall_left--;
			end else if (rx_idling && $urandom_range(0, 5) == 0) begin
				result_stall = 1'b1;
				stall_left = $urandom_range(0, 15);
			end else begin
				result_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cpsic_pkg::out_word_t expected;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_commands.size() == 0) begin
				$display("%0t: unexpected result word, current_command %0d speed_from_position %0d",
					$time, result.current_command, result.speed_from_position);
				mismatch_count++;
			end else begin
				expected = pending_commands.pop_front();
				if (result.current_command !== expected.current_command) begin
					$display("%0t: current_command expected %0d, got %0d", $time,
						expected.current_command, result.current_command);
					mismatch_count++;
				end
				if (result.speed_from_position !== expected.speed_from_position) begin
					$display("%0t: speed_from_position expected %0d, got %0d", $time,
						expected.speed_from_position, result.speed_from_position);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("cascaded_position_speed_iq_controller test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_valid = 1'b0;
		sample = '0;
		mismatch_count = 0;
		hold_off_cycles = 0;
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		mode_shadow = cpsic_pkg::MODE_SPEED;
		pos_gains_shadow = '0;
		speed_limit_shadow = cpsic_pkg::SPEED_LIMIT_RST;
		pi_gains_shadow = '0;
		path_gain_shadow = cpsic_pkg::PATH_GAIN_RST;
		current_limits_shadow = '0;
		ff_coef_shadow = '0;
		ff_torque_shadow = '0;
		speed_integral = '0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_speed_mode();
		test_position_mode();
		test_trajectory_mode();
		test_crossed_limits();
		test_gain_extremes();
		test_backpressure();
		test_integral_saturation();
		test_random();
		drain();
		repeat (40)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("cascaded_position_speed_iq_controller test passed");
		else
			$display("cascaded_position_speed_iq_controller test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/cpsic_pkg.sv
src/cpsic_mul.sv
src/cascaded_position_speed_iq_controller.sv
tb/sv/tb.sv
